>>> hw/rtl/cpba_pkg.sv
package cpba_pkg;

  // Field widths of the request and response words
  localparam int unsigned FUNC_W          = 1;
  localparam int unsigned BYTE_SIZE_W     = 22;
  localparam int unsigned BYTE_OFFSET_W   = 21;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned REGION_OFFSET_W = 21;
  localparam int unsigned PAGES_FREE_W    = 10;

  // The used bitmap is stored and scanned in words of MAP_W pages
  localparam int unsigned MAP_SHIFT = 3;
  localparam int unsigned MAP_W     = 1 << MAP_SHIFT;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_BAD_FREE  = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

endpackage

>>> hw/rtl/cpba_if.sv
interface cpba_req_if;
  import cpba_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [BYTE_SIZE_W-1:0]   byte_size;
  logic [BYTE_OFFSET_W-1:0] byte_offset;

  modport source (output valid, func, byte_size, byte_offset, input ready);
  modport sink   (input valid, func, byte_size, byte_offset, output ready);
endinterface

interface cpba_rsp_if;
  import cpba_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [REGION_OFFSET_W-1:0] region_offset;
  logic [PAGES_FREE_W-1:0]    pages_free;

  modport source (output valid, status, region_offset, pages_free, input ready);
  modport sink   (input valid, status, region_offset, pages_free, output ready);
endinterface

>>> hw/rtl/cpba_scan.sv
module cpba_scan #(
  parameter int unsigned POOL_PAGES,
  parameter int unsigned PG_W,
  parameter int unsigned CNT_W,
  parameter int unsigned WC_W
) (
  input  logic [cpba_pkg::MAP_W-1:0] word_i,
  input  logic [WC_W-1:0]            word_idx_i,
  input  logic [PG_W-1:0]            from_i,
  input  logic [CNT_W-1:0]           pages_i,
  input  logic [CNT_W-1:0]           run_i,
  output logic [CNT_W-1:0]           run_o,
  output logic                       found_o,
  output logic [PG_W-1:0]            start_o
);
  import cpba_pkg::*;

  localparam int unsigned PX_W = WC_W + MAP_SHIFT + 1;

  // Walk the pages of one bitmap word, carrying the free run length
  always_comb begin
    logic [CNT_W-1:0] run;
    logic [PX_W-1:0]  page;
    logic             active;
    run     = run_i;
    found_o = 1'b0;
    start_o = '0;
    for (int b = 0; b < MAP_W; b++) begin
      page   = {1'b0, word_idx_i, MAP_SHIFT'(b)};
      active = (page >= PX_W'(from_i)) && (page < PX_W'(POOL_PAGES));
      if (active && !found_o) begin
        if (word_i[b]) begin
          run = '0;
        end else begin
          run = run + 1'b1;
          if (run == pages_i) begin
            found_o = 1'b1;
            start_o = PG_W'(page + PX_W'(1) - PX_W'(pages_i));
          end
        end
      end
    end
    run_o = run;
  end

endmodule

>>> hw/rtl/cpba_mask.sv
module cpba_mask #(
  parameter int unsigned PG_W,
  parameter int unsigned WC_W
) (
  input  logic [WC_W-1:0]            word_idx_i,
  input  logic [PG_W-1:0]            lo_i,
  input  logic [PG_W-1:0]            hi_i,
  output logic [cpba_pkg::MAP_W-1:0] mask_o
);
  import cpba_pkg::*;

  localparam int unsigned PX_W = WC_W + MAP_SHIFT + 1;

  // Select the pages of this word that fall inside [lo, hi]
  always_comb begin
    logic [PX_W-1:0] page;
    for (int b = 0; b < MAP_W; b++) begin
      page      = {1'b0, word_idx_i, MAP_SHIFT'(b)};
      mask_o[b] = (page >= PX_W'(lo_i)) && (page <= PX_W'(hi_i));
    end
  end

endmodule

>>> hw/rtl/contiguous_page_bitmap_allocator_core.sv
// Free: check, look up the run record, then clear the bitmap words spanned by the run
// (8 pages per word). Allocate: check, scan words in one or two passes, then mark words.
// The single 8-page scan unit on the bitmap memory does the walking, and the block
// takes one item at a time.
// Reset: asynchronous, active low; a clearing pass then zeroes the bitmap and run
// records before ready rises.
module contiguous_page_bitmap_allocator_core #(
  parameter int unsigned POOL_PAGES = 512,
  parameter int unsigned PAGE_BITS  = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpba_req_if.sink   req_i,
  cpba_rsp_if.source rsp_o
);
  import cpba_pkg::*;

  localparam int unsigned PG_W   = $clog2(POOL_PAGES);
  localparam int unsigned CNT_W  = $clog2(POOL_PAGES + 1);
  localparam int unsigned NWORDS = (POOL_PAGES + MAP_W - 1) / MAP_W;
  localparam int unsigned WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned WC_W   = $clog2(NWORDS + 1);
  localparam int unsigned SUM_W  = BYTE_SIZE_W + 1;
  localparam int unsigned RQ_W   = BYTE_SIZE_W + 1 - PAGE_BITS;

  // Sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;  // clearing pass after reset
  localparam logic [3:0] S_IDLE   = 4'd1;  // wait for a request word
  localparam logic [3:0] S_CHECK  = 4'd2;  // size / range checks
  localparam logic [3:0] S_SCAN   = 4'd3;  // search the bitmap for a free run
  localparam logic [3:0] S_MARK   = 4'd4;  // set the run's bits
  localparam logic [3:0] S_FCHK   = 4'd5;  // look at the recorded run size
  localparam logic [3:0] S_UNMARK = 4'd6;  // clear the run's bits
  localparam logic [3:0] S_DONE   = 4'd7;  // hand the result to the output register

  logic [3:0] state_q, state_d;
  logic [PG_W-1:0] clr_q, clr_d;

  // Request word held for the whole operation
  logic [FUNC_W-1:0]        func_q;
  logic [BYTE_SIZE_W-1:0]   size_q;
  logic [BYTE_OFFSET_W-1:0] offs_q;

  // Allocator state
  logic [CNT_W-1:0] free_count_q, free_count_d;
  logic [PG_W-1:0]  next_index_q, next_index_d;

  // Working registers of the sequencer
  logic [CNT_W-1:0] pages_q, pages_d;
  logic             pass_q, pass_d;
  logic [PG_W-1:0]  from_q, from_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic [WC_W-1:0]  issue_w_q, issue_w_d;
  logic             dv_q, dv_d;
  logic [WC_W-1:0]  dw_q, dw_d;
  logic [WC_W-1:0]  end_w_q, end_w_d;
  logic [PG_W-1:0]  lo_q, lo_d;
  logic [PG_W-1:0]  hi_q, hi_d;
  status_e                    res_status_q, res_status_d;
  logic [REGION_OFFSET_W-1:0] res_region_q, res_region_d;

  // Output register
  logic                       rsp_valid_q, rsp_valid_d;
  logic                       out_load;
  logic [STATUS_W-1:0]        rsp_status_q;
  logic [REGION_OFFSET_W-1:0] rsp_region_q;
  logic [PAGES_FREE_W-1:0]    rsp_pages_q;

  // Used bitmap memory, MAP_W pages per entry
  logic [MAP_W-1:0] map_mem [NWORDS];
  logic [MAP_W-1:0] map_rd_q;
  logic             map_we;
  logic [WA_W-1:0]  map_wa;
  logic [MAP_W-1:0] map_wd;

  // Run size memory, one record per page
  logic [CNT_W-1:0] rs_mem [POOL_PAGES];
  logic [CNT_W-1:0] rs_rd_q;
  logic             rs_we;
  logic [PG_W-1:0]  rs_wa;
  logic [CNT_W-1:0] rs_wd;
  logic [PG_W-1:0]  rs_ra;

  // Shared units
  logic [CNT_W-1:0] scan_run;
  logic             scan_found;
  logic [PG_W-1:0]  scan_start;
  logic [MAP_W-1:0] mask;

  // Page count of an allocate, rounded up, at least one
  logic [SUM_W-1:0] size_sum;
  logic [RQ_W-1:0]  pg_raw;
  logic [RQ_W-1:0]  pg_req;
  logic [31:0]      idx_w;
  logic [31:0]      alloc_end;
  logic [31:0]      free_end;
  logic [31:0]      free_sum;
  logic [PG_W-1:0]  alloc_hi;
  logic [PG_W-1:0]  free_hi;
  logic             issue_ok;

  assign size_sum = {1'b0, size_q} + SUM_W'((1 << PAGE_BITS) - 1);
  assign pg_raw   = RQ_W'(size_sum >> PAGE_BITS);
  assign pg_req   = (pg_raw == '0) ? RQ_W'(1) : pg_raw;

  // Page index of a free; low offset bits drop out
  assign idx_w = 32'(offs_q >> PAGE_BITS);
  assign rs_ra = PG_W'(offs_q >> PAGE_BITS);

  assign alloc_end = 32'(scan_start) + 32'(pages_q) - 32'd1;
  assign alloc_hi  = PG_W'(alloc_end);
  // Clip a freed run at the pool end
  assign free_end  = 32'(rs_ra) + 32'(rs_rd_q) - 32'd1;
  assign free_hi   = (free_end >= POOL_PAGES) ? PG_W'(POOL_PAGES - 1) : PG_W'(free_end);
  assign free_sum  = 32'(free_count_q) + 32'(pages_q);

  assign issue_ok = (issue_w_q <= end_w_q);

  cpba_scan #(
    .POOL_PAGES (POOL_PAGES),
    .PG_W       (PG_W),
    .CNT_W      (CNT_W),
    .WC_W       (WC_W)
  ) u_scan (
    .word_i     (map_rd_q),
    .word_idx_i (dw_q),
    .from_i     (from_q),
    .pages_i    (pages_q),
    .run_i      (run_q),
    .run_o      (scan_run),
    .found_o    (scan_found),
    .start_o    (scan_start)
  );

  cpba_mask #(
    .PG_W (PG_W),
    .WC_W (WC_W)
  ) u_mask (
    .word_idx_i (dw_q),
    .lo_i       (lo_q),
    .hi_i       (hi_q),
    .mask_o     (mask)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    free_count_d = free_count_q;
    next_index_d = next_index_q;
    pages_d      = pages_q;
    pass_d       = pass_q;
    from_d       = from_q;
    run_d        = run_q;
    issue_w_d    = issue_w_q;
    dv_d         = 1'b0;
    dw_d         = dw_q;
    end_w_d      = end_w_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    res_status_d = res_status_q;
    res_region_d = res_region_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    out_load     = 1'b0;
    map_we       = 1'b0;
    map_wa       = '0;
    map_wd       = '0;
    rs_we        = 1'b0;
    rs_wa        = '0;
    rs_wd        = '0;

    // Stream word reads through the bitmap in the walking states
    if (state_q == S_SCAN || state_q == S_MARK || state_q == S_UNMARK) begin
      dv_d      = issue_ok;
      dw_d      = issue_w_q;
      issue_w_d = issue_w_q + WC_W'(issue_ok);
    end

    case (state_q)
      S_CLEAR: begin
        rs_we = 1'b1;
        rs_wa = clr_q;
        if (32'(clr_q) < NWORDS) begin
          map_we = 1'b1;
          map_wa = clr_q[WA_W-1:0];
        end
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == POOL_PAGES - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_status_d = ST_OK;
        res_region_d = '0;
        if (func_q == FUNC_ALLOC) begin
          if (32'(pg_req) > POOL_PAGES) begin
            res_status_d = ST_TOO_LARGE;
            state_d      = S_DONE;
          end else if (32'(pg_req) > 32'(free_count_q)) begin
            res_status_d = ST_NO_SPACE;
            state_d      = S_DONE;
          end else begin
            // First pass starts at the next-fit index
            pages_d   = CNT_W'(pg_req);
            pass_d    = 1'b0;
            from_d    = next_index_q;
            run_d     = '0;
            issue_w_d = WC_W'(next_index_q >> MAP_SHIFT);
            end_w_d   = WC_W'(NWORDS - 1);
            state_d   = S_SCAN;
          end
        end else begin
          if (idx_w >= POOL_PAGES) begin
            res_status_d = ST_BAD_FREE;
            state_d      = S_DONE;
          end else begin
            state_d = S_FCHK;
          end
        end
      end
      S_SCAN: begin
        if (dv_q) begin
          if (scan_found) begin
            lo_d      = scan_start;
            hi_d      = alloc_hi;
            issue_w_d = WC_W'(scan_start >> MAP_SHIFT);
            end_w_d   = WC_W'(alloc_hi >> MAP_SHIFT);
            dv_d      = 1'b0;
            state_d   = S_MARK;
          end else if (dw_q == end_w_q) begin
            dv_d = 1'b0;
            if (!pass_q) begin
              // Retry over the whole pool from page zero
              pass_d    = 1'b1;
              from_d    = '0;
              run_d     = '0;
              issue_w_d = '0;
            end else begin
              res_status_d = ST_NO_SPACE;
              state_d      = S_DONE;
            end
          end else begin
            run_d = scan_run;
          end
        end
      end
      S_MARK: begin
        if (dv_q) begin
          map_we = 1'b1;
          map_wa = dw_q[WA_W-1:0];
          map_wd = map_rd_q | mask;
          if (dw_q == end_w_q) begin
            rs_we        = 1'b1;
            rs_wa        = lo_q;
            rs_wd        = pages_q;
            free_count_d = free_count_q - pages_q;
            if (32'(lo_q) + 32'(pages_q) >= POOL_PAGES) begin
              next_index_d = '0;
            end else begin
              next_index_d = PG_W'(32'(lo_q) + 32'(pages_q));
            end
            res_region_d = REGION_OFFSET_W'(32'(lo_q) << PAGE_BITS);
            state_d      = S_DONE;
          end
        end
      end
      S_FCHK: begin
        if (rs_rd_q == '0) begin
          res_status_d = ST_BAD_FREE;
          state_d      = S_DONE;
        end else begin
          // Drop the record now; its length goes along in pages_q
          rs_we     = 1'b1;
          rs_wa     = rs_ra;
          pages_d   = rs_rd_q;
          lo_d      = rs_ra;
          hi_d      = free_hi;
          issue_w_d = WC_W'(rs_ra >> MAP_SHIFT);
          end_w_d   = WC_W'(free_hi >> MAP_SHIFT);
          state_d   = S_UNMARK;
        end
      end
      S_UNMARK: begin
        if (dv_q) begin
          map_we = 1'b1;
          map_wa = dw_q[WA_W-1:0];
          map_wd = map_rd_q & ~mask;
          if (dw_q == end_w_q) begin
            if (free_sum > POOL_PAGES) begin
              free_count_d = CNT_W'(POOL_PAGES);
            end else begin
              free_count_d = CNT_W'(free_sum);
            end
            next_index_d = lo_q;
            state_d      = S_DONE;
          end
        end
      end
      S_DONE: begin
        // Hold the result until the output register frees up
        if (!rsp_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      free_count_q <= CNT_W'(POOL_PAGES);
      next_index_q <= '0;
      pass_q       <= 1'b0;
      run_q        <= '0;
      issue_w_q    <= '0;
      dv_q         <= 1'b0;
      dw_q         <= '0;
      end_w_q      <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      free_count_q <= free_count_d;
      next_index_q <= next_index_d;
      pass_q       <= pass_d;
      run_q        <= run_d;
      issue_w_q    <= issue_w_d;
      dv_q         <= dv_d;
      dw_q         <= dw_d;
      end_w_q      <= end_w_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q <= req_i.func;
      size_q <= req_i.byte_size;
      offs_q <= req_i.byte_offset;
    end
    pages_q      <= pages_d;
    from_q       <= from_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    res_status_q <= res_status_d;
    res_region_q <= res_region_d;
    if (out_load) begin
      rsp_status_q <= res_status_q;
      rsp_region_q <= res_region_q;
      rsp_pages_q  <= PAGES_FREE_W'(free_count_q);
    end
  end

  // Bitmap memory: read the issued word every cycle
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rd_q <= map_mem[issue_w_q[WA_W-1:0]];
  end

  // Run size memory
  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rs_wa] <= rs_wd;
    end
    rs_rd_q <= rs_mem[rs_ra];
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.region_offset = rsp_region_q;
  assign rsp_o.pages_free    = rsp_pages_q;

endmodule
